@@ design/assert_macros.svh @@
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LAFA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LAFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

@@ design/lafa_pkg.sv @@
`timescale 1ns / 1ps
package lafa_pkg;

  localparam int MAX_HEAPS       = 8;
  localparam int RANGES_PER_HEAP = 32;
  localparam int NUM_RANGES      = MAX_HEAPS * RANGES_PER_HEAP;
  localparam int HEAP_W          = $clog2(MAX_HEAPS);
  localparam int IDX_W           = $clog2(RANGES_PER_HEAP);
  localparam int ADDR_W          = HEAP_W + IDX_W;
  localparam int BW              = 40;
  localparam int CW              = 43;
  localparam int AL_W            = 25;
  localparam int PASS_W          = 10;
  localparam int FRAME_W         = 3;

  localparam logic [BW-1:0] RESET_HEAP_BYTES = BW'(128 * 1024 * 1024);
  localparam logic [BW:0]   HEAP_GRAIN_MASK  = (BW+1)'(64 * 1024 - 1);
  localparam logic [BW-1:0] MASK40           = '1;

  typedef struct packed {
    logic [BW-1:0]      off;
    logic [BW-1:0]      len;
    logic [PASS_W-1:0]  first;
    logic [PASS_W-1:0]  last;
    logic [FRAME_W-1:0] frame;
  } range_t;

  typedef struct packed {
    logic [CW-1:0] aligned;
    logic          exceed;
    logic          clash;
  } scan_res_t;

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_RESET   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_EXISTING = 3'd0,
    ST_NEW_HEAP = 3'd1,
    ST_NO_HEAP  = 3'd2,
    ST_FULL     = 3'd3,
    ST_DONE     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_FSW_RD,
    S_FSW_CHK,
    S_REL_RD,
    S_REL_CHK,
    S_HEAP,
    S_CAND,
    S_RD,
    S_CHK,
    S_PLACE,
    S_OPEN,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

@@ design/lafa_range_ram.sv @@
`timescale 1ns / 1ps
module lafa_range_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [lafa_pkg::ADDR_W-1:0] wr_addr,
  input  lafa_pkg::range_t          wr_data,
  input  logic [lafa_pkg::ADDR_W-1:0] rd_addr,
  output lafa_pkg::range_t          rd_data
);

  lafa_pkg::range_t mem [lafa_pkg::NUM_RANGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/lafa_scan_unit.sv @@
`timescale 1ns / 1ps
module lafa_scan_unit (
  input  logic                         sel_entry,
  input  logic [lafa_pkg::CW-1:0]      cand,
  input  logic [lafa_pkg::BW-1:0]      size,
  input  logic [lafa_pkg::AL_W-1:0]    al,
  input  logic [lafa_pkg::BW-1:0]      hb,
  input  lafa_pkg::range_t             entry,
  input  logic                         entry_valid,
  input  logic [lafa_pkg::FRAME_W-1:0] cur_frame,
  input  logic [lafa_pkg::PASS_W-1:0]  first,
  input  logic [lafa_pkg::PASS_W-1:0]  last,
  output lafa_pkg::scan_res_t          res
);

  logic [lafa_pkg::CW-1:0] entry_end;
  logic [lafa_pkg::CW-1:0] op_a;
  logic [lafa_pkg::CW-1:0] mask;
  logic [lafa_pkg::CW-1:0] aligned;
  logic [lafa_pkg::CW-1:0] cand_end;
  logic                    lives;
  logic                    overlap;

  always_comb begin
    entry_end = lafa_pkg::CW'(entry.off) + lafa_pkg::CW'(entry.len);
    op_a      = sel_entry ? entry_end : cand;
    mask      = lafa_pkg::CW'(al) - lafa_pkg::CW'(1);
    aligned   = (al == '0) ? op_a : ((op_a + mask) & ~mask);
    cand_end  = cand + lafa_pkg::CW'(size);
    lives     = (entry.frame != cur_frame) || !((last < entry.first) || (first > entry.last));
    overlap   = !((cand_end <= lafa_pkg::CW'(entry.off)) || (cand >= entry_end));
    res.aligned = aligned;
    res.exceed  = (aligned + lafa_pkg::CW'(size)) > lafa_pkg::CW'(hb);
    res.clash   = entry_valid && lives && overlap;
  end

endmodule

@@ design/lifetime_aliasing_first_fit_allocator_core.sv @@
`timescale 1ns / 1ps
// Begin frame: take frame_index modulo the frame count, then clear every range of that frame.
// Release scans the range slots of an open heap, or goes straight to the result when the heap is not open.
// Allocate: walk the heap slots, try candidate offsets and read each range slot of the heap
// until a clash, then place the range or open a heap and post the result.
// Throughput: one item at a time; the next is accepted the cycle after the result registers.
// Synchronous active-high reset clears heaps, ranges and frame and restores the config registers.
module lifetime_aliasing_first_fit_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    frame_index,
  input  logic [4:0]                    memory_type,
  input  logic [lafa_pkg::BW-1:0]       size_bytes,
  input  logic [lafa_pkg::AL_W-1:0]     alignment,
  input  logic [lafa_pkg::PASS_W-1:0]   first_pass,
  input  logic [lafa_pkg::PASS_W-1:0]   last_pass,
  input  logic [2:0]                    release_heap,
  input  logic [lafa_pkg::BW-1:0]       release_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    status,
  output logic [2:0]                    heap_slot,
  output logic [lafa_pkg::BW-1:0]       offset,
  output logic [lafa_pkg::BW-1:0]       new_heap_bytes,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [lafa_pkg::BW-1:0]       cfg_data
);

  `include "assert_macros.svh"

  lafa_pkg::state_t state, state_next;

  logic [3:0]                    frame_count;
  logic [lafa_pkg::BW-1:0]       default_heap_bytes;
  logic [lafa_pkg::FRAME_W-1:0]  cur_frame;
  logic [lafa_pkg::MAX_HEAPS-1:0]  heap_valid;
  logic [lafa_pkg::BW-1:0]       heap_bytes [lafa_pkg::MAX_HEAPS];
  logic [4:0]                    heap_type  [lafa_pkg::MAX_HEAPS];
  logic [lafa_pkg::NUM_RANGES-1:0] range_valid;

  logic [7:0]                    fidx_q;
  logic [4:0]                    mtype_q;
  logic [lafa_pkg::BW-1:0]       size_q;
  logic [lafa_pkg::AL_W-1:0]     al_q;
  logic [lafa_pkg::PASS_W-1:0]   first_q;
  logic [lafa_pkg::PASS_W-1:0]   last_q;
  logic [lafa_pkg::BW-1:0]       roff_q;
  logic [7:0]                    rem;
  logic [lafa_pkg::HEAP_W-1:0]   hsel;
  logic [lafa_pkg::ADDR_W-1:0]   ptr;
  logic [lafa_pkg::CW-1:0]       cand;

  logic [2:0]                    res_status;
  logic [2:0]                    res_slot;
  logic [lafa_pkg::BW-1:0]       res_offset;
  logic [lafa_pkg::BW-1:0]       res_newb;

  logic [lafa_pkg::AL_W-1:0]     al_msb;
  logic [3:0]                    frame_n;
  logic [lafa_pkg::RANGES_PER_HEAP-1:0] heap_rv;
  logic [lafa_pkg::IDX_W-1:0]    free_idx;
  logic                          free_found;
  logic [lafa_pkg::HEAP_W-1:0]   open_idx;
  logic                          open_found;
  logic [lafa_pkg::BW:0]         grain_up;
  logic [lafa_pkg::BW-1:0]       open_bytes;
  logic                          heap_match;
  logic                          last_heap;
  logic                          last_idx;

  logic                          wr_en;
  logic [lafa_pkg::ADDR_W-1:0]   wr_addr;
  lafa_pkg::range_t              wr_data;
  lafa_pkg::range_t              rd_data;
  lafa_pkg::scan_res_t           scan;

  lafa_range_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (ptr),
    .rd_data (rd_data)
  );

  lafa_scan_unit u_scan (
    .sel_entry   (state == lafa_pkg::S_CHK),
    .cand        (cand),
    .size        (size_q),
    .al          (al_q),
    .hb          (heap_bytes[hsel]),
    .entry       (rd_data),
    .entry_valid (range_valid[ptr]),
    .cur_frame   (cur_frame),
    .first       (first_q),
    .last        (last_q),
    .res         (scan)
  );

  assign in_ready  = (state == lafa_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    al_msb = '0;
    for (int i = 0; i < lafa_pkg::AL_W; i++) begin
      if (alignment[i]) begin
        al_msb    = '0;
        al_msb[i] = 1'b1;
      end
    end
    frame_n = (frame_count == 4'd0) ? 4'd1 : ((frame_count > 4'd8) ? 4'd8 : frame_count);
    heap_rv = range_valid[hsel*lafa_pkg::RANGES_PER_HEAP +: lafa_pkg::RANGES_PER_HEAP];
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = lafa_pkg::RANGES_PER_HEAP - 1; i >= 0; i--) begin
      if (!heap_rv[i]) begin
        free_idx   = lafa_pkg::IDX_W'(i);
        free_found = 1'b1;
      end
    end
    open_idx   = '0;
    open_found = 1'b0;
    for (int i = lafa_pkg::MAX_HEAPS - 1; i >= 0; i--) begin
      if (!heap_valid[i]) begin
        open_idx   = lafa_pkg::HEAP_W'(i);
        open_found = 1'b1;
      end
    end
    grain_up = ((lafa_pkg::BW+1)'(size_q) + lafa_pkg::HEAP_GRAIN_MASK) &
               ~lafa_pkg::HEAP_GRAIN_MASK;
    if (size_q > default_heap_bytes) begin
      open_bytes = grain_up[lafa_pkg::BW] ? lafa_pkg::MASK40 : grain_up[lafa_pkg::BW-1:0];
    end else begin
      open_bytes = default_heap_bytes;
    end
    heap_match = heap_valid[hsel] && (heap_type[hsel] == mtype_q);
    last_heap  = (hsel == lafa_pkg::HEAP_W'(lafa_pkg::MAX_HEAPS - 1));
    last_idx   = (ptr[lafa_pkg::IDX_W-1:0] == lafa_pkg::IDX_W'(lafa_pkg::RANGES_PER_HEAP - 1));
  end

  always_comb begin
    state_next    = state;
    wr_en         = 1'b0;
    wr_addr       = {hsel, free_idx};
    wr_data.off   = cand[lafa_pkg::BW-1:0];
    wr_data.len   = size_q;
    wr_data.first = first_q;
    wr_data.last  = last_q;
    wr_data.frame = cur_frame;
    case (state)
      lafa_pkg::S_IDLE: begin
        if (in_valid) begin
          case (kind)
            lafa_pkg::KIND_FRAME:   state_next = lafa_pkg::S_MOD;
            lafa_pkg::KIND_ALLOC:   state_next = lafa_pkg::S_HEAP;
            lafa_pkg::KIND_RELEASE: state_next = heap_valid[release_heap] ?
                                                 lafa_pkg::S_REL_RD : lafa_pkg::S_DONE;
            default:                state_next = lafa_pkg::S_CLEAR;
          endcase
        end
      end
      lafa_pkg::S_MOD: begin
        if (rem < {4'd0, frame_n}) begin
          state_next = lafa_pkg::S_FSW_RD;
        end
      end
      lafa_pkg::S_FSW_RD: state_next = lafa_pkg::S_FSW_CHK;
      lafa_pkg::S_FSW_CHK: begin
        state_next = (ptr == '1) ? lafa_pkg::S_DONE : lafa_pkg::S_FSW_RD;
      end
      lafa_pkg::S_REL_RD: state_next = lafa_pkg::S_REL_CHK;
      lafa_pkg::S_REL_CHK: begin
        state_next = last_idx ? lafa_pkg::S_DONE : lafa_pkg::S_REL_RD;
      end
      lafa_pkg::S_HEAP: begin
        if (heap_match) begin
          state_next = lafa_pkg::S_CAND;
        end else if (last_heap) begin
          state_next = lafa_pkg::S_OPEN;
        end
      end
      lafa_pkg::S_CAND: begin
        if (scan.exceed) begin
          state_next = last_heap ? lafa_pkg::S_OPEN : lafa_pkg::S_HEAP;
        end else begin
          state_next = lafa_pkg::S_RD;
        end
      end
      lafa_pkg::S_RD: state_next = lafa_pkg::S_CHK;
      lafa_pkg::S_CHK: begin
        if (scan.clash) begin
          state_next = lafa_pkg::S_CAND;
        end else if (last_idx) begin
          state_next = lafa_pkg::S_PLACE;
        end else begin
          state_next = lafa_pkg::S_RD;
        end
      end
      lafa_pkg::S_PLACE: begin
        wr_en      = free_found;
        state_next = lafa_pkg::S_DONE;
      end
      lafa_pkg::S_OPEN: begin
        wr_en       = open_found;
        wr_addr     = {open_idx, lafa_pkg::IDX_W'(0)};
        wr_data.off = '0;
        state_next  = lafa_pkg::S_DONE;
      end
      lafa_pkg::S_CLEAR: state_next = lafa_pkg::S_DONE;
      lafa_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = lafa_pkg::S_IDLE;
        end
      end
      default: state_next = lafa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lafa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count        <= 4'd2;
      default_heap_bytes <= lafa_pkg::RESET_HEAP_BYTES;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) begin
        frame_count <= cfg_data[3:0];
      end else begin
        default_heap_bytes <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lafa_pkg::S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lafa_pkg::S_DONE && (!out_valid || out_ready)) begin
      status         <= res_status;
      heap_slot      <= res_slot;
      offset         <= res_offset;
      new_heap_bytes <= res_newb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_frame   <= '0;
      heap_valid  <= '0;
      range_valid <= '0;
    end else begin
      case (state)
        lafa_pkg::S_MOD: begin
          if (rem < {4'd0, frame_n}) begin
            cur_frame <= rem[lafa_pkg::FRAME_W-1:0];
          end
        end
        lafa_pkg::S_FSW_CHK: begin
          if (rd_data.frame == cur_frame) begin
            range_valid[ptr] <= 1'b0;
          end
        end
        lafa_pkg::S_REL_CHK: begin
          if (rd_data.off == roff_q && rd_data.len == size_q &&
              {5'd0, rd_data.frame} == fidx_q) begin
            range_valid[ptr] <= 1'b0;
          end
        end
        lafa_pkg::S_PLACE: begin
          if (free_found) begin
            range_valid[{hsel, free_idx}] <= 1'b1;
          end
        end
        lafa_pkg::S_OPEN: begin
          if (open_found) begin
            heap_valid[open_idx] <= 1'b1;
            range_valid[open_idx*lafa_pkg::RANGES_PER_HEAP +: lafa_pkg::RANGES_PER_HEAP] <=
              lafa_pkg::RANGES_PER_HEAP'(1);
          end
        end
        lafa_pkg::S_CLEAR: begin
          heap_valid  <= '0;
          range_valid <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lafa_pkg::S_IDLE: begin
        fidx_q     <= frame_index;
        rem        <= frame_index;
        mtype_q    <= memory_type;
        size_q     <= size_bytes;
        al_q       <= al_msb;
        first_q    <= first_pass;
        last_q     <= last_pass;
        roff_q     <= release_offset;
        hsel       <= '0;
        ptr        <= {release_heap, lafa_pkg::IDX_W'(0)};
        res_status <= lafa_pkg::ST_DONE;
        res_slot   <= '0;
        res_offset <= '0;
        res_newb   <= '0;
      end
      lafa_pkg::S_MOD: begin
        if (rem < {4'd0, frame_n}) begin
          ptr <= '0;
        end else begin
          rem <= rem - {4'd0, frame_n};
        end
      end
      lafa_pkg::S_FSW_CHK, lafa_pkg::S_REL_CHK: begin
        ptr <= ptr + lafa_pkg::ADDR_W'(1);
      end
      lafa_pkg::S_HEAP: begin
        if (heap_match) begin
          cand <= '0;
        end else if (!last_heap) begin
          hsel <= hsel + lafa_pkg::HEAP_W'(1);
        end
      end
      lafa_pkg::S_CAND: begin
        if (scan.exceed) begin
          if (!last_heap) begin
            hsel <= hsel + lafa_pkg::HEAP_W'(1);
          end
        end else begin
          cand <= scan.aligned;
          ptr  <= {hsel, lafa_pkg::IDX_W'(0)};
        end
      end
      lafa_pkg::S_CHK: begin
        if (scan.clash) begin
          cand <= scan.aligned;
        end else if (!last_idx) begin
          ptr <= ptr + lafa_pkg::ADDR_W'(1);
        end
      end
      lafa_pkg::S_PLACE: begin
        res_status <= free_found ? lafa_pkg::ST_EXISTING : lafa_pkg::ST_FULL;
        res_slot   <= 3'(hsel);
        res_offset <= cand[lafa_pkg::BW-1:0];
      end
      lafa_pkg::S_OPEN: begin
        if (open_found) begin
          heap_bytes[open_idx] <= open_bytes;
          heap_type[open_idx]  <= mtype_q;
          res_status <= lafa_pkg::ST_NEW_HEAP;
          res_slot   <= 3'(open_idx);
          res_newb   <= open_bytes;
        end else begin
          res_status <= lafa_pkg::ST_NO_HEAP;
        end
      end
      default: begin
      end
    endcase
  end

  `LAFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `LAFA_ASSERT_SAME(a_newb_only_new, out_valid && status != lafa_pkg::ST_NEW_HEAP,
                    new_heap_bytes == '0)
  `LAFA_ASSERT_SAME(a_done_zero, out_valid && status == lafa_pkg::ST_DONE,
                    heap_slot == 3'd0 && offset == '0)
  `LAFA_ASSERT_NEXT(a_clear_all, state == lafa_pkg::S_CLEAR,
                    heap_valid == '0 && range_valid == '0)

endmodule
